### hdl/sil_pkg.sv
// Shared types and codes for the sorted insertion list.
`default_nettype none
package sil_pkg;

   localparam int DATA_W = 32;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DUMP   = 1'b1;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef struct packed {
      logic insert;
      logic rotate;
   } cell_ctrl_type;

endpackage
`default_nettype wire

### hdl/sil_cell.sv
// One storage cell of the sorted chain: compare, shift on insert, rotate on dump.
`default_nettype none
module sil_cell (
   input  wire                    clock,
   input  sil_pkg::cell_ctrl_type ctrl,
   input  sil_pkg::data_type      ins_value,
   input  wire                    occupied,
   input  wire                    prev_ge,
   input  sil_pkg::data_type      prev_value,
   input  sil_pkg::data_type      rot_value,
   output logic                   ge,
   output sil_pkg::data_type      value
);
   import sil_pkg::*;

   data_type value_ff;
   data_type value_in;

   assign ge    = !occupied || (value_ff >= ins_value);
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert) begin
         if (prev_ge) begin
            value_in = prev_value;
         end else if (ge) begin
            value_in = ins_value;
         end
      end else if (ctrl.rotate) begin
         value_in = rot_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

### hdl/sorted_insertion_list.sv
// Top level of the sorted insertion list: cell chain, insert and dump control.
//
//   channel | dir | tdata         | tuser          | tlast
//   req_    | in  | [31:0] value  | [0] operation  | -
//   rsp_    | out | [31:0] sorted | [0] overflowed | last of dump
//
// On insert, all cells compare the new value at once and shift.
// Dump holds req_tready low from its beat until the last result beat is loaded; result
// beats follow one per cycle while rsp_tready stays high, and a stall holds the dump.
// Dump of an empty store returns no result beat.
// The chain rotates once per result beat and is back in place after the last beat.
// Reset empties the store and clears overflow.
// A stalled result holds its beat; an insert may proceed under a stalled last beat.
`default_nettype none
module sorted_insertion_list #(
   parameter int CAPACITY = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] value
   input  wire  [0:0]  req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser    // [0] overflowed
);
   import sil_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DUMP = 1'b1;

   logic              state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  remain_ff, remain_in;
   logic              overflow_ff, overflow_in;
   logic              rsp_valid_ff, rsp_valid_in;
   data_type          rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_user_ff, rsp_user_in;

   cell_ctrl_type     ctrl;
   data_type          ins_value;
   logic              accept;
   logic              full;
   logic              load;
   data_type          cell_value [CAPACITY];
   logic              cell_ge    [CAPACITY];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign ins_value  = data_type'(req_tdata);
   assign load       = (state_ff == ST_DUMP) && (!rsp_valid_ff || rsp_tready);

   assign ctrl.insert = accept && (req_tuser[0] == OP_INSERT) && !full;
   assign ctrl.rotate = load;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic     occupied;
      logic     prev_ge;
      data_type prev_value;
      data_type rot_value;

      assign occupied = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign prev_ge    = 1'b0;
         assign prev_value = ins_value;
      end else begin : g_body
         assign prev_ge    = cell_ge[i-1];
         assign prev_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_end
         assign rot_value = cell_value[0];
      end else begin : g_mid
         assign rot_value = (count_ff == CNT_W'(i + 1)) ? cell_value[0] : cell_value[i+1];
      end

      sil_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .ins_value  (ins_value),
         .occupied   (occupied),
         .prev_ge    (prev_ge),
         .prev_value (prev_value),
         .rot_value  (rot_value),
         .ge         (cell_ge[i]),
         .value      (cell_value[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser[0] == OP_INSERT) begin
                  if (full) begin
                     overflow_in = 1'b1;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (count_ff != '0) begin
                  remain_in = count_ff;
                  state_in  = ST_DUMP;
               end
            end
         end
         ST_DUMP: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = cell_value[0];
               rsp_last_in  = (remain_ff == CNT_W'(1));
               rsp_user_in  = overflow_ff;
               remain_in    = remain_ff - CNT_W'(1);
               if (remain_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_user_ff;

endmodule
`default_nettype wire

### hdl/sil_checker.sv
// Port-level checks for the sorted insertion list, bound to the top level.
`default_nettype none
module sil_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire [31:0] req_tdata,
   input wire [0:0]  req_tuser,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata,
   input wire        rsp_tlast,
   input wire [0:0]  rsp_tuser
);
   import sil_pkg::*;

   logic unused_req;
   assign unused_req = req_tvalid ^ (^req_tdata) ^ req_tuser[0] ^ (req_tuser[0] == OP_DUMP);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   a_dump_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken in the middle of a dump");

   a_overflow_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> !rsp_tvalid || (rsp_tuser == $past(rsp_tuser)))
      else $error("overflow flag changed within a dump");

endmodule

bind sorted_insertion_list sil_checker u_sil_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

### test/sorted_insertion_list_tb.sv
// Testbench for the sorted insertion list: directed table, random inserts and dumps, scoreboard.
`timescale 1ns / 1ps
module sorted_insertion_list_tb;
   import sil_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int ITEM_TARGET = 270;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic       op;
      data_type   value;
      logic       typed;
      logic [1:0] exp_n;
      data_type   exp_lo;
      data_type   exp_hi;
   } stim_row_type;

   typedef struct packed {
      data_type value;
      logic     last;
      logic     ovf;
   } dump_beat_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;

   data_type      sorted_store [CAPACITY];
   int unsigned   stored_n = 0;
   logic          overflow_seen = 1'b0;
   dump_beat_type pending_dump_beats [$];
   dump_beat_type want;
   dump_beat_type got;
   stim_row_type  directed_rows [$];
   stim_row_type  row;
   logic          beat_typed;
   logic [1:0]    beat_exp_n;
   data_type      beat_exp_lo;
   data_type      beat_exp_hi;
   logic          steady_run;
   int unsigned   rsp_stall = 0;
   int unsigned   mismatches = 0;
   int unsigned   cycle_count = 0;
   int unsigned   items_sent;

   sorted_insertion_list #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady_run) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   function automatic void store_insert(data_type v);
      int unsigned pos;
      if (stored_n >= CAPACITY) begin
         overflow_seen = 1'b1;
         return;
      end
      pos = 0;
      while (pos < stored_n && sorted_store[pos] < v) pos++;
      for (int unsigned k = stored_n; k > pos; k--) sorted_store[k] = sorted_store[k - 1];
      sorted_store[pos] = v;
      stored_n++;
   endfunction

   function automatic void add_row(logic op, data_type v, logic typed, logic [1:0] n,
                                   data_type lo, data_type hi);
      stim_row_type r;
      r.op     = op;
      r.value  = v;
      r.typed  = typed;
      r.exp_n  = n;
      r.exp_lo = lo;
      r.exp_hi = hi;
      directed_rows.push_back(r);
   endfunction

   task automatic send_item(stim_row_type r);
      int unsigned gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid  <= 1'b1;
      req_tdata   <= r.value;
      req_tuser   <= r.op;
      beat_typed  = r.typed;
      beat_exp_n  = r.exp_n;
      beat_exp_lo = r.exp_lo;
      beat_exp_hi = r.exp_hi;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall = pick_gap();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata;
            got.last  = rsp_tlast;
            got.ovf   = rsp_tuser[0];
            if (pending_dump_beats.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual %0d last %0b ovf %0b",
                        $time, got.value, got.last, got.ovf);
               mismatches++;
            end else begin
               want = pending_dump_beats.pop_front();
               if (got.value !== want.value) begin
                  $display("%0t: sorted_value expected %0d actual %0d",
                           $time, want.value, got.value);
                  mismatches++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
                  mismatches++;
               end
               if (got.ovf !== want.ovf) begin
                  $display("%0t: overflowed expected %0b actual %0b",
                           $time, want.ovf, got.ovf);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == OP_INSERT) begin
               store_insert(req_tdata);
            end else if (beat_typed) begin
               for (int k = 0; k < beat_exp_n; k++) begin
                  want.value = (k == 0) ? beat_exp_lo : beat_exp_hi;
                  want.last  = (k + 1 == beat_exp_n);
                  want.ovf   = 1'b0;
                  pending_dump_beats.push_back(want);
               end
            end else begin
               for (int unsigned k = 0; k < stored_n; k++) begin
                  want.value = sorted_store[k];
                  want.last  = (k + 1 == stored_n);
                  want.ovf   = overflow_seen;
                  pending_dump_beats.push_back(want);
               end
            end
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = OP_INSERT;
      steady_run    = 1'b0;
      items_sent    = 0;
      beat_typed    = 1'b0;
      beat_exp_n    = '0;
      beat_exp_lo   = '0;
      beat_exp_hi   = '0;

      add_row(OP_DUMP,   32'sh00000000, 1'b1, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'sh7fffffff, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'sh80000000, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_DUMP,   32'shffffffff, 1'b1, 2'd2, 32'sh80000000, 32'sh7fffffff);
      add_row(OP_INSERT, 32'sh00000000, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'shffffffff, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'sh00000000, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'sh7fffffff, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_DUMP,   32'sh00000000, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'sh80000000, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'sh55555555, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'shaaaaaaaa, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'sh00000001, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'shfffffffe, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'sh12345678, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'sh80000001, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'sh7ffffffe, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'sh00010000, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'shffffff9c, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_DUMP,   32'sh00000000, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'sh00000000, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_DUMP,   32'sh00000000, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_INSERT, 32'sh80000000, 1'b0, 2'd0, 32'sh0, 32'sh0);
      add_row(OP_DUMP,   32'sh00000000, 1'b0, 2'd0, 32'sh0, 32'sh0);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         send_item(directed_rows[k]);
         items_sent++;
      end

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(29) == 0) steady_run = ~steady_run;
         row.op     = ($urandom_range(99) < 80) ? OP_DUMP : OP_INSERT;
         row.value  = $urandom;
         row.typed  = 1'b0;
         row.exp_n  = '0;
         row.exp_lo = '0;
         row.exp_hi = '0;
         send_item(row);
         items_sent++;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_dump_beats.size() != 0) @(posedge clock);
      repeat (2 * CAPACITY + 8) @(posedge clock);

      if (mismatches == 0 && pending_dump_beats.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### sim.f
hdl/sil_pkg.sv
hdl/sil_cell.sv
hdl/sorted_insertion_list.sv
hdl/sil_checker.sv
test/sorted_insertion_list_tb.sv
